// File: src/bgbm_pkg.sv
`timescale 1ns / 1ps

package bgbm_pkg;

    // Field widths
    localparam int COORD_W    = 6;
    localparam int DIST_W     = 6;
    localparam int GRID_W     = 7;
    // Holds a clamped grid size up to the largest MAX_ROWS / MAX_COLS (256)
    localparam int LIM_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Transaction kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_MERGE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NBR_DIST  = 2'd2;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } nbr_t;

endpackage

// File: src/bgbm_ram.sv
`timescale 1ns / 1ps

module bgbm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: src/bgbm_nbr_unit.sv
`timescale 1ns / 1ps

// Shared add/subtract and bound check: one neighbor coordinate per cycle.
module bgbm_nbr_unit (
    input  logic [bgbm_pkg::COORD_W-1:0] row,
    input  logic [bgbm_pkg::COORD_W-1:0] col,
    input  bgbm_pkg::dir_t               dir,
    input  logic [bgbm_pkg::DIST_W-1:0]  nbr_dist,
    input  logic [bgbm_pkg::LIM_W-1:0]   rows_used,
    input  logic [bgbm_pkg::LIM_W-1:0]   cols_used,
    output bgbm_pkg::nbr_t               nbr
);

    localparam int CW = bgbm_pkg::COORD_W;
    localparam int LW = bgbm_pkg::LIM_W;

    logic          vert;
    logic [CW-1:0] op;
    logic [LW-1:0] lim;
    logic [CW:0]   diff;
    logic [CW:0]   sum;
    logic [CW-1:0] coord;
    logic          ok;

    always_comb begin
        vert = (dir == bgbm_pkg::DIR_UP) || (dir == bgbm_pkg::DIR_DOWN);
        op   = vert ? row : col;
        lim  = vert ? rows_used : cols_used;
        diff = {1'b0, op} - {1'b0, nbr_dist};
        sum  = {1'b0, op} + {1'b0, nbr_dist};
        case (dir)
            bgbm_pkg::DIR_UP, bgbm_pkg::DIR_LEFT: begin
                ok    = !diff[CW];
                coord = diff[CW-1:0];
            end
            bgbm_pkg::DIR_DOWN, bgbm_pkg::DIR_RIGHT: begin
                ok    = {{(LW-CW-1){1'b0}}, sum} < lim;
                coord = sum[CW-1:0];
            end
            default: begin
                ok    = 1'b0;
                coord = op;
            end
        endcase
        nbr.hit = ok;
        nbr.row = vert ? coord : row;
        nbr.col = vert ? col : coord;
    end

endmodule

// File: src/binary_grid_border_map.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tdata: cell_row, cell_col, cell_value; tuser: kind
// m_        out  m_tvalid/m_tready    tdata: stored_bit, is_border
// cfg_      in   cfg_we               cfg_index, cfg_data (no read-back)
//
// Write and merge complete on accept. A query inside the grid reads the cell and
// its in-grid neighbors one per cycle through the single port of the cell memory,
// then loads the result register. An out-of-grid query goes straight to that load.
// After reset the memory is cleared one cell a cycle, all MAX_ROWS * MAX_COLS cells
// (4096 by default), with s_tready low. A query result waits in the output
// register; the next query stalls in its last cycle only while that is full.
module binary_grid_border_map #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // cell_row[5:0], cell_col[11:6], cell_value[12]
    input  logic [1:0]                        s_tuser,  // kind[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // stored_bit[0], is_border[1]
    input  logic                              cfg_we,
    input  logic [bgbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW    = bgbm_pkg::COORD_W;
    localparam int LW    = bgbm_pkg::LIM_W;
    localparam int GW    = bgbm_pkg::GRID_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NBR,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              clr_cnt_reg;
    logic [CW-1:0]              row_reg;
    logic [CW-1:0]              col_reg;
    bgbm_pkg::dir_t             dir_reg;
    logic                       self_reg;
    logic                       border_reg;
    logic                       rd_self_reg;
    logic                       rd_nbr_reg;
    logic                       m_tvalid_reg;
    logic [7:0]                 m_tdata_reg;

    logic [GW-1:0]              grid_rows_reg;
    logic [GW-1:0]              grid_cols_reg;
    logic [bgbm_pkg::DIST_W-1:0] dist_reg;

    logic [1:0]                 in_kind;
    logic [CW-1:0]              in_row;
    logic [CW-1:0]              in_col;
    logic                       in_value;
    logic                       s_fire;
    logic [LW-1:0]              rows_used;
    logic [LW-1:0]              cols_used;
    logic                       in_inside;
    logic [AW-1:0]              in_addr;
    bgbm_pkg::nbr_t             nbr;
    logic [AW-1:0]              nbr_addr;

    logic                       ram_en;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic                       ram_wdata;
    logic                       ram_rdata;

    logic                       self_cur;
    logic                       border_cur;
    logic                       out_free;

    assign in_kind  = s_tuser;
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_value = s_tdata[12];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Grid sizes above the storage limits act as the limits
    always_comb begin
        rows_used = ({{(LW-GW){1'b0}}, grid_rows_reg} > LW'(MAX_ROWS)) ?
                    LW'(MAX_ROWS) : {{(LW-GW){1'b0}}, grid_rows_reg};
        cols_used = ({{(LW-GW){1'b0}}, grid_cols_reg} > LW'(MAX_COLS)) ?
                    LW'(MAX_COLS) : {{(LW-GW){1'b0}}, grid_cols_reg};
        in_inside = ({{(LW-CW){1'b0}}, in_row} < rows_used) &&
                    ({{(LW-CW){1'b0}}, in_col} < cols_used);
        in_addr   = AW'(int'(in_row) * MAX_COLS + int'(in_col));
        nbr_addr  = AW'(int'(nbr.row) * MAX_COLS + int'(nbr.col));
    end

    bgbm_nbr_unit u_nbr (
        .row       (row_reg),
        .col       (col_reg),
        .dir       (dir_reg),
        .nbr_dist  (dist_reg),
        .rows_used (rows_used),
        .cols_used (cols_used),
        .nbr       (nbr)
    );

    // Single memory port: clear sweep, write/merge/self read on accept,
    // neighbor reads while sequencing. OR with 0 leaves a cell unchanged.
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = in_addr;
        ram_wdata = in_value;
        case (state_reg)
            ST_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 1'b0;
            end
            ST_IDLE: begin
                if (s_fire && in_inside) begin
                    if (in_kind == bgbm_pkg::KIND_WRITE) begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                    end else if (in_kind == bgbm_pkg::KIND_MERGE && in_value) begin
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = 1'b1;
                    end else if (in_kind == bgbm_pkg::KIND_QUERY) begin
                        ram_en = 1'b1;
                    end
                end
            end
            ST_NBR: begin
                ram_en   = nbr.hit;
                ram_addr = nbr_addr;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    bgbm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_cells (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Read data lands in the cycle after the address; fold it in as it arrives
    always_comb begin
        self_cur   = rd_self_reg ? ram_rdata : self_reg;
        border_cur = border_reg | (rd_nbr_reg & (ram_rdata != self_cur));
        out_free   = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= GW'(8);
            grid_cols_reg <= GW'(8);
            dist_reg      <= bgbm_pkg::DIST_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                bgbm_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data[GW-1:0];
                bgbm_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data[GW-1:0];
                bgbm_pkg::REG_NBR_DIST:  dist_reg      <= cfg_data[bgbm_pkg::DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            rd_self_reg  <= 1'b0;
            rd_nbr_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // ST_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire && in_kind == bgbm_pkg::KIND_QUERY) begin
                        row_reg    <= in_row;
                        col_reg    <= in_col;
                        dir_reg    <= bgbm_pkg::DIR_UP;
                        self_reg   <= 1'b0;
                        border_reg <= 1'b0;
                        rd_nbr_reg <= 1'b0;
                        // out-of-grid query answers zero without reads
                        rd_self_reg <= in_inside;
                        state_reg   <= in_inside ? ST_NBR : ST_DONE;
                    end
                end
                ST_NBR: begin
                    self_reg    <= self_cur;
                    border_reg  <= border_cur;
                    rd_self_reg <= 1'b0;
                    rd_nbr_reg  <= nbr.hit;
                    dir_reg     <= bgbm_pkg::dir_t'(dir_reg + 2'd1);
                    if (dir_reg == bgbm_pkg::DIR_RIGHT) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    self_reg    <= self_cur;
                    border_reg  <= border_cur;
                    rd_self_reg <= 1'b0;
                    rd_nbr_reg  <= 1'b0;
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, border_cur, self_cur};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_we_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR) || s_fire)
        else $error("cell memory written outside clear sweep or accepted transaction");

    a_rd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_self_reg && rd_nbr_reg))
        else $error("self and neighbor read data pending together");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_kind == bgbm_pkg::KIND_QUERY) |=> !s_tready)
        else $error("ready right after an accepted query");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final query step");
`endif

endmodule
